// ----- sv/pidis_pkg.sv -----
package pidis_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ERR_W      = 17;
	localparam int DIFF_W     = 18;
	localparam int INTEG_W    = 33;
	localparam int RAW_W      = 34;
	localparam int DERIV_W    = 34;
	localparam int GAIN_W     = 24;
	localparam int STEP_W     = 16;
	localparam int LIMIT_W    = 32;
	localparam int MUL_A_W    = 25;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = 60;
	localparam int DRIVE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Fractional bits dropped from the integral product and from the final sum.
	localparam int INTEG_FRAC = 16;
	localparam int OUT_FRAC   = 8;
	// The derivative is split into a low unsigned part and a high signed part.
	localparam int DERIV_LO_W = 17;

	localparam logic [STEP_W-1:0] TIME_STEP_RST    = 16'hFFFF;
	localparam logic [STEP_W-1:0] INVERSE_STEP_RST = 16'h0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_TIME_STEP   = 3'd3,
		REG_INVERSE_STEP = 3'd4,
		REG_SEP_THRESH  = 3'd5,
		REG_INTEG_LIMIT = 3'd6,
		REG_OUTPUT_MODE = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SAT,
		ST_DONE
	} state_t;

	// Multiply issued in each step of the run; the step after the last one
	// issues nothing. Stepping back from the first step lands on OP_NONE.
	typedef enum logic [2:0] {
		OP_ERR_TS   = 3'd0,
		OP_KP_ERR   = 3'd1,
		OP_DIFF_INV = 3'd2,
		OP_KI_LO    = 3'd3,
		OP_KI_HI    = 3'd4,
		OP_KD_LO    = 3'd5,
		OP_KD_HI    = 3'd6,
		OP_NONE     = 3'd7
	} op_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

// ----- sv/pidis_ifs.sv -----
interface pidis_in_if import pidis_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] target;
	logic signed [SAMPLE_W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidis_out_if import pidis_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

// ----- sv/pid_integral_separation_top.sv -----
// Channel   Dir  Payload                        Word accepted when
// in_ch     in   target[15:0], measured[15:0]   in_ch.valid && in_ch.ready
// out_ch    out  drive[31:0]                    out_ch.valid && out_ch.ready
// cfg       in   cfg_index[2:0], cfg_data[31:0] cfg_we
//
// Each word runs seven products through the single 25x18 multiplier, one
// accumulate per cycle behind it; the sum is then saturated in ST_SAT and the
// output is formed in ST_DONE, which holds while a result waits on out_ch.
// in_ch.ready is high only in idle; a result waiting on out_ch does not stop a
// new word from being accepted, but the next result waits until it is taken.
// arst_n clears the controller state and loads the register reset values.
module pid_integral_separation_top import pidis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pidis_in_if.sink              in_ch,
	pidis_out_if.source           out_ch
);

	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [STEP_W-1:0]  time_step_q, inverse_step_q, sep_thresh_q;
	logic [LIMIT_W-1:0] integ_limit_q;
	logic               output_mode_q;

	state_t state_q, state_d;
	op_t    step_q, step_d, cons_op;

	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   last_err_q;
	logic signed [DRIVE_W-1:0] last_out_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;

	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic                      sep_q;
	logic signed [RAW_W-1:0]   integ_raw_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DRIVE_W-1:0] pos_q;

	logic                      in_acc, out_load, running;
	logic [ERR_W-1:0]          err_mag;
	mul_req_t                  mul_req;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [RAW_W-1:0]   lim_pos, lim_neg;
	logic signed [INTEG_W-1:0] integ_clamped;
	logic signed [ACC_W-OUT_FRAC-1:0] acc_sh;
	logic signed [DRIVE_W-1:0] pos_sat;
	logic signed [DRIVE_W:0]   inc_raw;
	logic signed [DRIVE_W-1:0] inc_sat, drive_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			time_step_q    <= TIME_STEP_RST;
			inverse_step_q <= INVERSE_STEP_RST;
			sep_thresh_q   <= '0;
			integ_limit_q  <= '0;
			output_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:    prop_gain_q    <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   integ_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_TIME_STEP:    time_step_q    <= cfg_data[STEP_W-1:0];
				REG_INVERSE_STEP: inverse_step_q <= cfg_data[STEP_W-1:0];
				REG_SEP_THRESH:   sep_thresh_q   <= cfg_data[STEP_W-1:0];
				REG_INTEG_LIMIT:  integ_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_OUTPUT_MODE:  output_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= OP_ERR_TS;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_acc   = 1'b0;
		out_load = 1'b0;
		running  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_acc = in_ch.valid;
				if (in_ch.valid) begin
					state_d = ST_RUN;
					step_d  = OP_ERR_TS;
				end
			end
			ST_RUN: begin
				running = 1'b1;
				step_d  = op_t'(step_q + 3'd1);
				if (step_q == OP_NONE) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ch.ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	// The product in the register was issued one step earlier.
	assign cons_op     = op_t'(step_q - 3'd1);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_req = '0;
		if (running) begin
			case (step_q)
				OP_ERR_TS: begin
					mul_req.a = {{(MUL_A_W-STEP_W){1'b0}}, time_step_q};
					mul_req.b = {err_q[ERR_W-1], err_q};
				end
				OP_KP_ERR: begin
					mul_req.a = {1'b0, prop_gain_q};
					mul_req.b = {err_q[ERR_W-1], err_q};
				end
				OP_DIFF_INV: begin
					mul_req.a = {{(MUL_A_W-STEP_W){1'b0}}, inverse_step_q};
					mul_req.b = diff_q;
				end
				OP_KI_LO: begin
					mul_req.a = {1'b0, integ_gain_q};
					mul_req.b = {{(MUL_B_W-INTEG_FRAC){1'b0}}, integ_q[INTEG_FRAC-1:0]};
				end
				OP_KI_HI: begin
					mul_req.a = {1'b0, integ_gain_q};
					mul_req.b = {integ_q[INTEG_W-1], integ_q[INTEG_W-1:INTEG_FRAC]};
				end
				OP_KD_LO: begin
					mul_req.a = {1'b0, deriv_gain_q};
					mul_req.b = {1'b0, deriv_q[DERIV_LO_W-1:0]};
				end
				OP_KD_HI: begin
					mul_req.a = {1'b0, deriv_gain_q};
					mul_req.b = {deriv_q[DERIV_W-1], deriv_q[DERIV_W-1:DERIV_LO_W]};
				end
				default: mul_req = '0;
			endcase
		end
	end

	pidis_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.prod_s1 (prod_s1)
	);

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign err_mag  = err_q[ERR_W-1] ? -err_q : err_q;

	// Clamp of the integral to the configured magnitude.
	assign lim_pos = {{(RAW_W-LIMIT_W){1'b0}}, integ_limit_q};
	assign lim_neg = -lim_pos;
	always_comb begin
		if (integ_raw_q > lim_pos) begin
			integ_clamped = lim_pos[INTEG_W-1:0];
		end else if (integ_raw_q < lim_neg) begin
			integ_clamped = lim_neg[INTEG_W-1:0];
		end else begin
			integ_clamped = integ_raw_q[INTEG_W-1:0];
		end
	end

	// Floor to a whole number and saturate to 32 bits.
	assign acc_sh = acc_q[ACC_W-1:OUT_FRAC];
	always_comb begin
		if (acc_sh[ACC_W-OUT_FRAC-1:DRIVE_W-1] == '0 ||
				acc_sh[ACC_W-OUT_FRAC-1:DRIVE_W-1] == '1) begin
			pos_sat = acc_sh[DRIVE_W-1:0];
		end else if (acc_sh[ACC_W-OUT_FRAC-1]) begin
			pos_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			pos_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	assign inc_raw = {pos_q[DRIVE_W-1], pos_q} - {last_out_q[DRIVE_W-1], last_out_q};
	always_comb begin
		if (inc_raw[DRIVE_W] == inc_raw[DRIVE_W-1]) begin
			inc_sat = inc_raw[DRIVE_W-1:0];
		end else if (inc_raw[DRIVE_W]) begin
			inc_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			inc_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end
	assign drive_d = output_mode_q ? inc_sat : pos_q;

	// Controller state that persists from word to word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			last_err_q  <= '0;
			last_out_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (running && step_q == OP_ERR_TS) begin
				last_err_q <= err_q;
			end
			if (running && cons_op == OP_KP_ERR) begin
				integ_q <= integ_clamped;
			end
			if (out_load) begin
				last_out_q  <= pos_q;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of one word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q <= {in_ch.target[SAMPLE_W-1], in_ch.target}
				- {in_ch.measured[SAMPLE_W-1], in_ch.measured};
		end
		if (running && step_q == OP_ERR_TS) begin
			sep_q  <= err_mag < {1'b0, sep_thresh_q};
			diff_q <= {err_q[ERR_W-1], err_q} - {last_err_q[ERR_W-1], last_err_q};
		end
		if (running) begin
			case (cons_op)
				OP_ERR_TS: begin
					integ_raw_q <= sep_q
						? {integ_q[INTEG_W-1], integ_q} + prod_s1[RAW_W-1:0]
						: {integ_q[INTEG_W-1], integ_q};
				end
				OP_KP_ERR:   acc_q   <= prod_ext;
				OP_DIFF_INV: deriv_q <= prod_s1[DERIV_W-1:0];
				// The low half of the integral product is non-negative, so its
				// floor is a plain shift.
				OP_KI_LO: begin
					acc_q <= acc_q + ACC_W'(prod_s1[GAIN_W+INTEG_FRAC-1:INTEG_FRAC]);
				end
				OP_KI_HI: acc_q <= acc_q + prod_ext;
				OP_KD_LO: acc_q <= acc_q + prod_ext;
				OP_KD_HI: acc_q <= acc_q + {prod_s1, {DERIV_LO_W{1'b0}}};
				default: ;
			endcase
		end
		if (state_q == ST_SAT) begin
			pos_q <= pos_sat;
		end
		if (out_load) begin
			drive_q <= drive_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.drive = drive_q;

endmodule

// ----- sv/pidis_mul.sv -----
module pidis_mul import pidis_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(req.a) * $signed(req.b);
	end

endmodule

// ----- sv/pidis_chk.sv -----
module pidis_chk import pidis_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DRIVE_W-1:0] drive
);

	// The block is busy right after it takes a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a word was accepted");

	// A word occupies the multiplier for the full sequence.
	a_busy_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##9 !in_ready)
		else $error("input ready before the sequence could finish");

	// A new result appears only at the end of a busy period.
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

	// A stalled result holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("stalled result changed or dropped");

endmodule

bind pid_integral_separation_top pidis_chk u_pidis_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.drive     (out_ch.drive)
);
